// File: design/iocr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocr_pkg: shared constants and types for the completion reorder buffer
// Window depth, sequence number width and payload width, with derived widths.
// ----------------------------------------------------------------------------
package iocr_pkg;

    localparam int WINDOW       = 32;
    localparam int ID_BITS      = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int SEQ_PORT_BITS = 16;
    localparam int PAY_PORT_BITS = 32;

    localparam int IDX_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_BITS = IDX_BITS + 1;

    typedef logic [ID_BITS-1:0]      seq_t;
    typedef logic [PAYLOAD_BITS-1:0] pay_t;
    typedef logic [IDX_BITS-1:0]     idx_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    localparam logic STATUS_RELEASE = 1'b0;
    localparam logic STATUS_REJECT  = 1'b1;

endpackage

// File: design/in_order_completion_reorder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A rejected request gives its result in the cycle after acceptance; a
// release run follows the drain state and the registered slot RAM read.
// One request is accepted per cycle while idle and the output is free,
// then one result is released per cycle while the output is not stalled.
// Reset: synchronous, clears the valid map and control state.
// ----------------------------------------------------------------------------
// in_order_completion_reorder: completion reorder buffer
// Stores out-of-order completions in a window RAM by sequence number and
// releases consecutive entries in order, flagging stale, duplicate or out-of-window ids.
// ----------------------------------------------------------------------------
module in_order_completion_reorder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_seq_id,
    input  logic [31:0] s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_seq_id,
    output logic [31:0] m_out_payload,
    output logic        m_status,
    output logic        m_last
);

    iocr_pkg::state_t state_reg, state_next;
    iocr_pkg::seq_t   expect_reg;
    iocr_pkg::idx_t   head_reg;
    logic [iocr_pkg::WINDOW-1:0] valid_reg;

    iocr_pkg::pay_t   slot_mem [iocr_pkg::WINDOW];
    iocr_pkg::pay_t   rd_data_reg;

    logic             m_valid_reg;
    iocr_pkg::seq_t   m_seq_reg;
    logic             m_status_reg;
    logic             m_last_reg;

    iocr_pkg::seq_t   in_id;
    iocr_pkg::pay_t   in_pay;
    iocr_pkg::seq_t   offset;
    logic             in_window;
    logic [iocr_pkg::SUM_BITS-1:0] slot_sum;
    iocr_pkg::idx_t   slot;
    logic             reject;
    logic             accept;
    logic             out_free;
    logic             store_en;
    logic             issue;
    iocr_pkg::idx_t   head_inc;

    assign in_id     = iocr_pkg::ID_BITS'(s_seq_id);
    assign in_pay    = iocr_pkg::PAYLOAD_BITS'(s_payload);
    assign offset    = in_id - expect_reg;
    assign in_window = offset < iocr_pkg::ID_BITS'(iocr_pkg::WINDOW);
    assign slot_sum  = iocr_pkg::SUM_BITS'(head_reg)
                     + iocr_pkg::SUM_BITS'(offset[iocr_pkg::IDX_BITS-1:0]);

    always_comb begin
        if (slot_sum >= iocr_pkg::SUM_BITS'(iocr_pkg::WINDOW)) begin
            slot = iocr_pkg::IDX_BITS'(slot_sum - iocr_pkg::SUM_BITS'(iocr_pkg::WINDOW));
        end else begin
            slot = iocr_pkg::IDX_BITS'(slot_sum);
        end
    end

    always_comb begin
        if (head_reg == iocr_pkg::IDX_BITS'(iocr_pkg::WINDOW - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg + iocr_pkg::IDX_BITS'(1);
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == iocr_pkg::S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign reject   = !in_window || valid_reg[slot];
    assign store_en = accept && !reject;
    assign issue    = (state_reg == iocr_pkg::S_DRAIN) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            iocr_pkg::S_IDLE: begin
                if (store_en && (slot == head_reg)) begin
                    state_next = iocr_pkg::S_DRAIN;
                end
            end
            iocr_pkg::S_DRAIN: begin
                if (issue && !valid_reg[head_inc]) begin
                    state_next = iocr_pkg::S_IDLE;
                end
            end
            default: state_next = iocr_pkg::S_IDLE;
        endcase
    end

    // slot RAM: one write port on store, one registered read port on release
    always_ff @(posedge aclk) begin
        if (store_en) begin
            slot_mem[slot] <= in_pay;
        end
        if (issue) begin
            rd_data_reg <= slot_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= iocr_pkg::S_IDLE;
            expect_reg  <= iocr_pkg::ID_BITS'(1);
            head_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (store_en) begin
                valid_reg[slot] <= 1'b1;
            end
            if (issue) begin
                valid_reg[head_reg] <= 1'b0;
                head_reg            <= head_inc;
                expect_reg          <= expect_reg + iocr_pkg::ID_BITS'(1);
            end
            if (issue || (accept && reject)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            m_seq_reg    <= expect_reg;
            m_status_reg <= iocr_pkg::STATUS_RELEASE;
            m_last_reg   <= !valid_reg[head_inc];
        end else if (accept && reject) begin
            m_seq_reg    <= in_id;
            m_status_reg <= iocr_pkg::STATUS_REJECT;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_seq_id = iocr_pkg::SEQ_PORT_BITS'(m_seq_reg);
    assign m_out_payload = (m_status_reg == iocr_pkg::STATUS_REJECT) ?
                           '0 : iocr_pkg::PAY_PORT_BITS'(rd_data_reg);
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

endmodule

// File: design/iocr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocr_checker: port-level checks for the completion reorder buffer
// Watches reject results, input back-pressure and release run ordering.
// ----------------------------------------------------------------------------
module iocr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_out_seq_id,
    input logic [31:0] m_out_payload,
    input logic        m_status,
    input logic        m_last
);

    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == iocr_pkg::STATUS_REJECT)) |-> m_last)
        else $error("reject result without last");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == iocr_pkg::STATUS_REJECT)) |-> (m_out_payload == 32'd0))
        else $error("reject result carries payload");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !(s_valid && s_ready))
        else $error("request taken while result stalled");

    a_run_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (m_status == iocr_pkg::STATUS_RELEASE) && !m_last) |=>
        (m_valid && (m_status == iocr_pkg::STATUS_RELEASE)
         && (m_out_seq_id == $past(m_out_seq_id) + 16'd1)))
        else $error("release run broken or out of order");

endmodule

bind in_order_completion_reorder iocr_checker u_iocr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_seq_id  (m_out_seq_id),
    .m_out_payload (m_out_payload),
    .m_status      (m_status),
    .m_last        (m_last)
);
